// File: hw/rtl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared constants, opcodes and request/response types of the LRU
// key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int ENTRIES = 16;
    localparam int KeyW    = 32;
    localparam int ValW    = 32;
    localparam int CapW    = 5;
    localparam int IdxW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int AgeW    = IdxW;
    localparam int CountW  = $clog2(ENTRIES + 1);
    localparam int LimW    = (CountW > CapW) ? CountW : CapW;

    localparam logic [CapW-1:0] CAP_RESET = CapW'(16);

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } lkvc_op_t;

    typedef struct packed {
        lkvc_op_t            op;
        logic [KeyW-1:0]     key;
        logic [ValW-1:0]     value;
    } lkvc_req_t;

    typedef struct packed {
        logic                found;
        logic [ValW-1:0]     value;
    } lkvc_resp_t;

endpackage

// File: hw/rtl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative 16-entry key-value cache with least-recently-used
// replacement. A get returns one result item; a put returns none.
// A get passes through the input register and then the result register.
// Throughput: one item per cycle, unless a get waits on a stalled, full result register.
// Reset clears all entries, the entry count and both pipeline registers,
// and sets the capacity to 16. No clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_key_value_cache (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  logic [lkvc_pkg::CapW-1:0]   cfg_write_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        opcode,
    input  logic signed [31:0]          lookup_key,
    input  logic signed [31:0]          store_value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        found,
    output logic signed [31:0]          read_value
);
    import lkvc_pkg::*;

    logic [CapW-1:0] capacity_reg;
    logic            in_valid_reg;
    logic            in_valid_next;
    lkvc_req_t       in_req_reg;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            found_reg;
    logic [ValW-1:0] value_reg;
    lkvc_resp_t      resp;
    logic            advance;
    logic            accept;
    logic            load_out;

    // A put never waits on the output side; a get waits only for a free
    // result register.
    assign advance  = in_valid_reg &&
                      ((in_req_reg.op == OP_PUT) || !out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;
    assign load_out = advance && (in_req_reg.op == OP_GET);

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAP_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                capacity_reg <= cfg_write_data;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_req_reg.op    <= lkvc_op_t'(opcode);
            in_req_reg.key   <= $unsigned(lookup_key);
            in_req_reg.value <= $unsigned(store_value);
        end
        if (load_out)
        begin
            found_reg <= resp.found;
            value_reg <= resp.value;
        end
    end

    lkvc_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (advance),
        .req      (in_req_reg),
        .capacity (capacity_reg),
        .resp     (resp)
    );

    assign out_valid  = out_valid_reg;
    assign found      = found_reg;
    assign read_value = $signed(value_reg);

endmodule

// File: hw/rtl/lkvc_table.sv
// ----------------------------------------------------------------------------
// lkvc_table
// Register-held entry table: parallel key match, age tracking, victim and
// free-slot selection, and the state update for one request per cycle while fire is high.
// ----------------------------------------------------------------------------
module lkvc_table (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       fire,
    input  lkvc_pkg::lkvc_req_t        req,
    input  logic [lkvc_pkg::CapW-1:0]  capacity,
    output lkvc_pkg::lkvc_resp_t       resp
);
    import lkvc_pkg::*;

    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [KeyW-1:0]    key_reg   [ENTRIES];
    logic [KeyW-1:0]    key_next  [ENTRIES];
    logic [ValW-1:0]    value_reg [ENTRIES];
    logic [ValW-1:0]    value_next[ENTRIES];
    logic [AgeW-1:0]    age_reg   [ENTRIES];
    logic [AgeW-1:0]    age_next  [ENTRIES];
    logic [CountW-1:0]  count_reg;
    logic [CountW-1:0]  count_next;

    logic [ENTRIES-1:0] hit_vec;
    logic               hit;
    logic [IdxW-1:0]    hit_idx;
    logic [AgeW-1:0]    hit_age;
    logic [ValW-1:0]    hit_value;
    logic [IdxW-1:0]    free_idx;
    logic [IdxW-1:0]    victim_idx;
    logic [CountW-1:0]  count_m1;
    logic [AgeW-1:0]    oldest_age;
    logic [LimW-1:0]    limit;
    logic               full;
    logic [IdxW-1:0]    slot;

    // Match, victim and free-slot search. Valid keys are distinct and valid
    // ages are distinct, so the match and victim vectors are one-hot.
    always_comb
    begin
        count_m1   = count_reg - CountW'(1);
        oldest_age = count_m1[AgeW-1:0];
        hit_idx    = '0;
        hit_age    = '0;
        hit_value  = '0;
        victim_idx = '0;
        free_idx   = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec[i] = valid_reg[i] && (key_reg[i] == req.key);
            if (hit_vec[i])
            begin
                hit_idx   = hit_idx | IdxW'(i);
                hit_age   = hit_age | age_reg[i];
                hit_value = hit_value | value_reg[i];
            end
            if (valid_reg[i] && (age_reg[i] == oldest_age))
            begin
                victim_idx = victim_idx | IdxW'(i);
            end
        end
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IdxW'(i);
            end
        end
        hit = |hit_vec;
    end

    // A capacity of zero acts as one; anything above the table size saturates.
    always_comb
    begin
        if (capacity == '0)
        begin
            limit = LimW'(1);
        end
        else if (LimW'(capacity) > LimW'(ENTRIES))
        begin
            limit = LimW'(ENTRIES);
        end
        else
        begin
            limit = LimW'(capacity);
        end
        full = LimW'(count_reg) >= limit;
        slot = full ? victim_idx : free_idx;
    end

    assign resp.found = hit;
    assign resp.value = hit_value;

    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            key_next[i]   = key_reg[i];
            value_next[i] = value_reg[i];
            age_next[i]   = age_reg[i];
        end
        if (fire)
        begin
            if (hit)
            begin
                // Touch: entries younger than the hit entry age by one.
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (valid_reg[i] && !hit_vec[i] && (age_reg[i] < hit_age))
                    begin
                        age_next[i] = age_reg[i] + AgeW'(1);
                    end
                end
                age_next[hit_idx] = '0;
                if (req.op == OP_PUT)
                begin
                    value_next[hit_idx] = req.value;
                end
            end
            else if (req.op == OP_PUT)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (valid_reg[i])
                    begin
                        age_next[i] = age_reg[i] + AgeW'(1);
                    end
                end
                valid_next[slot] = 1'b1;
                key_next[slot]   = req.key;
                value_next[slot] = req.value;
                age_next[slot]   = '0;
                if (!full)
                begin
                    count_next = count_reg + CountW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            key_reg[i]   <= key_next[i];
            value_reg[i] <= value_next[i];
            age_reg[i]   <= age_next[i];
        end
    end

endmodule

// File: hw/rtl/lkvc_checker.sv
// ----------------------------------------------------------------------------
// lkvc_checker
// Port-level checks of the LRU key-value cache, bound to the top level.
// ----------------------------------------------------------------------------
module lkvc_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic                      found,
    input logic signed [31:0]        read_value
);

    // A waiting result item is neither dropped nor changed.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(found) && $stable(read_value))
        else $error("result item changed or dropped while stalled");

    // A miss carries a zero value.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> read_value == 32'sd0)
        else $error("miss result with nonzero value");

    // With the output register empty, a get goes from the input register to
    // the result register at once, so a new result item rises only after its
    // input item was taken and held in the input register.
    a_rise_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result item without an accepted input item");

    // Reset empties the output register at once.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result item shown during reset");

endmodule

bind lru_key_value_cache lkvc_checker u_checker (.*);
